// ===== hdl/pvf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvf_pkg
// Shared widths, constants and controller/datapath interface types for the
// plurality vote block.
// ----------------------------------------------------------------------------
package pvf_pkg;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned HIT_W       = 12;
  localparam int unsigned BEST_CNT_W  = 12;
  localparam int unsigned PCT_W       = 15;
  // 4095 * 25600 fits in 27 bits
  localparam int unsigned DIVIDEND_W  = HIT_W + PCT_W;

  localparam logic [PCT_W-1:0]      FULL_SCALE_Q8 = PCT_W'(25600);
  localparam logic [BEST_CNT_W-1:0] BEST_CNT_MAX  = '1;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF    = 12;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the request
    logic vote;      // update the table
    logic mul;       // form dividend, decide saturation
    logic div_step;  // one quotient bit
    logic clear;     // result shown, empty the table
  } pvf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic go_div;
  } pvf_status_t;

endpackage

// ===== hdl/pvf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvf_ctrl
// Sequencer: vote update, then on the last vote the multiply, the
// bit-serial division when it is needed, and the result strobe.
// ----------------------------------------------------------------------------
module pvf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pvf_pkg::pvf_status_t status,
  output pvf_pkg::pvf_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_VOTE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int unsigned STEP_W = $clog2(pvf_pkg::PCT_W);

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_VOTE;
      end
      S_VOTE: begin
        state_next = status.last ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        step_next  = STEP_W'(pvf_pkg::PCT_W - 1);
        state_next = status.go_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (step == '0) state_next = S_OUT;
        else            step_next  = step - 1'b1;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_OUT);
  assign cmd.load     = (state == S_IDLE) && start;
  assign cmd.vote     = (state == S_VOTE);
  assign cmd.mul      = (state == S_MUL);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.clear    = (state == S_OUT);

endmodule

// ===== hdl/pvf_dp.sv =====
// ----------------------------------------------------------------------------
// pvf_dp
// Identifier table with parallel match, running best entry, and the
// restoring divider for the winning percentage.
// ----------------------------------------------------------------------------
module pvf_dp #(
  parameter int unsigned TABLE_ENTRIES = pvf_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS    = pvf_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pvf_pkg::pvf_cmd_t                   cmd,
  output pvf_pkg::pvf_status_t                status,
  input  logic                                has_id,
  input  logic [pvf_pkg::ID_W-1:0]            source_id,
  input  logic                                last,
  input  logic [pvf_pkg::HIT_W-1:0]           hit_total,
  output logic                                found,
  output logic [pvf_pkg::ID_W-1:0]            best_id,
  output logic [pvf_pkg::BEST_CNT_W-1:0]      best_count,
  output logic [pvf_pkg::PCT_W-1:0]           percent_q8,
  output logic                                table_overflow,
  output logic                                percent_saturated
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CW = (COUNT_BITS > pvf_pkg::HIT_W) ? COUNT_BITS : pvf_pkg::HIT_W;
  localparam int unsigned HW = pvf_pkg::HIT_W;
  localparam int unsigned QW = pvf_pkg::PCT_W;
  localparam int unsigned DW = pvf_pkg::DIVIDEND_W;

  // captured request
  logic                  req_has_id;
  logic [pvf_pkg::ID_W-1:0] req_id;
  logic                  req_last;
  logic [HW-1:0]         req_hit;

  // table
  logic [pvf_pkg::ID_W-1:0] ids  [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]    cnts [TABLE_ENTRIES];
  logic [UW-1:0]            used;
  logic                     dropped;

  // running winner
  logic [COUNT_BITS-1:0]    best_cnt;
  logic [AW-1:0]            best_idx;
  logic [pvf_pkg::ID_W-1:0] best_id_r;

  // divider
  logic [HW-1:0] rem;
  logic [QW-1:0] quo;
  logic          found_r, sat_r;

  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic [COUNT_BITS-1:0]    hit_cnt, cand_cnt;
  logic [AW-1:0]            hit_idx, cand_idx;
  logic                     room, cand;
  logic [CW-1:0]            best_ext;
  logic [DW-1:0]            product;
  logic [HW:0]              trial;
  logic                     trial_ge;
  logic                     found_now, sat_now;

  always_comb begin
    hit_cnt = '0;
    hit_idx = '0;
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      match[n] = (UW'(n) < used) && (ids[n] == req_id);
      if (match[n]) begin
        hit_cnt = hit_cnt | cnts[n];
        hit_idx = hit_idx | AW'(n);
      end
    end
    hit  = |match;
    room = (used < UW'(TABLE_ENTRIES));
    if (hit) begin
      cand_cnt = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
      cand_idx = hit_idx;
    end else begin
      cand_cnt = COUNT_BITS'(1);
      cand_idx = used[AW-1:0];
    end
    cand = req_has_id && (hit || room);
  end

  assign best_ext  = CW'(best_cnt);
  assign found_now = (used != '0);
  assign sat_now   = found_now &&
                     ((req_hit == '0) || (best_ext > CW'(req_hit)));
  assign product   = DW'(best_ext[HW-1:0]) * DW'(pvf_pkg::FULL_SCALE_Q8);
  assign trial     = {rem, quo[QW-1]};
  assign trial_ge  = (trial >= {1'b0, req_hit});

  assign status.last   = req_last;
  assign status.go_div = found_now && !sat_now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_has_id <= has_id;
      req_id     <= source_id;
      req_last   <= last;
      req_hit    <= hit_total;
    end
    if (cmd.vote && req_has_id) begin
      for (int n = 0; n < TABLE_ENTRIES; n++) begin
        if (match[n]) begin
          cnts[n] <= cand_cnt;
        end else if (!hit && room && (used[AW-1:0] == AW'(n))) begin
          ids[n]  <= req_id;
          cnts[n] <= COUNT_BITS'(1);
        end
      end
    end
    if (cmd.mul) begin
      found_r <= found_now;
      sat_r   <= sat_now;
      rem     <= product[DW-1:QW];
      quo     <= product[QW-1:0];
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? HW'(trial - {1'b0, req_hit}) : trial[HW-1:0];
      quo <= {quo[QW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      used      <= '0;
      dropped   <= 1'b0;
      best_cnt  <= '0;
      best_idx  <= '0;
      best_id_r <= '0;
    end else if (cmd.vote && req_has_id) begin
      if (!hit) begin
        if (room) used <= used + 1'b1;
        else      dropped <= 1'b1;
      end
      // earliest entry wins a tie
      if (cand && ((cand_cnt > best_cnt) ||
                   ((cand_cnt == best_cnt) && (cand_idx < best_idx)))) begin
        best_cnt  <= cand_cnt;
        best_idx  <= cand_idx;
        best_id_r <= req_id;
      end
    end
  end

  assign found             = found_r;
  assign best_id           = best_id_r;
  assign best_count        = (best_ext > CW'(pvf_pkg::BEST_CNT_MAX)) ?
                             pvf_pkg::BEST_CNT_MAX : best_ext[HW-1:0];
  assign percent_q8        = !found_r ? '0 : (sat_r ? pvf_pkg::FULL_SCALE_Q8 : quo);
  assign table_overflow    = dropped;
  assign percent_saturated = sat_r;

endmodule

// ===== hdl/plurality_vote_with_fraction_top.sv =====
// ----------------------------------------------------------------------------
// plurality_vote_with_fraction_top
// Plurality vote over a group of identifier votes with winning fraction.
// ----------------------------------------------------------------------------
// Usage:
//   A request (one vote) is taken on a rising edge with start high and busy
//   low. has_id, source_id, last and hit_total travel with it.
//   A vote without last is captured, then the table is updated once, with
//   every entry compared in parallel.
//   A vote with last adds a multiply step, then the restoring divider
//   yields one quotient bit per cycle, then the result state; the divider
//   is skipped when nothing was found or the percentage saturates.
//   The result is on the result ports for the single cycle in which done is
//   high; best_id and best_count then clear, and it cannot be stalled.
//   After the result the table and the overflow flag are emptied.
//   Reset (rst, synchronous) returns the sequencer to idle and empties the
//   table; table contents themselves are not cleared.
// ----------------------------------------------------------------------------
module plurality_vote_with_fraction_top #(
  parameter int unsigned TABLE_ENTRIES = pvf_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS    = pvf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           has_id,
  input  logic [pvf_pkg::ID_W-1:0]       source_id,
  input  logic                           last,
  input  logic [pvf_pkg::HIT_W-1:0]      hit_total,
  output logic                           done,
  output logic                           found,
  output logic [pvf_pkg::ID_W-1:0]       best_id,
  output logic [pvf_pkg::BEST_CNT_W-1:0] best_count,
  output logic [pvf_pkg::PCT_W-1:0]      percent_q8,
  output logic                           table_overflow,
  output logic                           percent_saturated
);

  pvf_pkg::pvf_cmd_t    cmd;
  pvf_pkg::pvf_status_t status;

  pvf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pvf_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .has_id            (has_id),
    .source_id         (source_id),
    .last              (last),
    .hit_total         (hit_total),
    .found             (found),
    .best_id           (best_id),
    .best_count        (best_count),
    .percent_q8        (percent_q8),
    .table_overflow    (table_overflow),
    .percent_saturated (percent_saturated)
  );

endmodule
